### hdl/quadtree_tile_viewport_macros.svh
// assertion macros used by the checker file
`ifndef QUADTREE_TILE_VIEWPORT_MACROS_SVH
`define QUADTREE_TILE_VIEWPORT_MACROS_SVH

// same-cycle implication, held off during reset
`define QTV_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("quadtree_tile_viewport: implication check failed");

// next-cycle implication, held off during reset
`define QTV_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("quadtree_tile_viewport: next-cycle check failed");

`endif

### hdl/qtv_pkg.sv
// shared constants, types and helpers of the tile viewport
`default_nettype none

package qtv_pkg;

  localparam int LEVEL_W     = 5;
  localparam int TILE_W      = 20;
  localparam int PAN_W       = 21;
  localparam int SIZE_W      = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_ZOOM   = 20;
  localparam int DEF_MAX_VIEW_W = 8;
  localparam int DEF_MAX_VIEW_H = 8;

  // navigation event codes
  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZOOM_IN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZOOM_OUT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PAN      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // effective window size after saturation
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } view_size_t;

  // clip a window dimension to its maximum
  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] value,
                                                 input logic [SIZE_W-1:0] limit);
    sat_size = (value > limit) ? limit : value;
  endfunction

endpackage

`default_nettype wire

### hdl/qtv_queue.sv
// two-entry job queue between the event front end and the tile scanner
`default_nettype none

module qtv_queue
  import qtv_pkg::*;
#(
  parameter int W = 45
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [W-1:0]     entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/qtv_front.sv
// event front end: applies zoom and pan to the view state and queues a scan job
`default_nettype none

module qtv_front
  import qtv_pkg::*;
#(
  parameter int MAX_ZOOM = DEF_MAX_ZOOM,
  parameter int CW       = DEF_MAX_ZOOM
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [MODE_W-1:0]       mode,
  input  wire logic [PAN_W-1:0]        pan_dx,
  input  wire logic [PAN_W-1:0]        pan_dy,
  input  wire view_size_t              view,
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output logic [LEVEL_W+2*CW-1:0]      job_data
);

  // sum width holds center plus signed pan without overflow
  localparam int SW = ((CW > PAN_W) ? CW : PAN_W) + 2;

  logic [LEVEL_W-1:0] level;
  logic [CW-1:0]      col;
  logic [CW-1:0]      row;
  logic [LEVEL_W-1:0] level_next;
  logic [CW-1:0]      col_next;
  logic [CW-1:0]      row_next;
  logic [SW-1:0]      map_max;
  logic signed [SW-1:0] col_sum;
  logic signed [SW-1:0] row_sum;
  logic               accept;

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign map_max   = (SW'(1) << level) - SW'(1);

  // signed pan sums
  assign col_sum = $signed({{(SW-CW){1'b0}}, col}) +
                   $signed({{(SW-PAN_W){pan_dx[PAN_W-1]}}, pan_dx});
  assign row_sum = $signed({{(SW-CW){1'b0}}, row}) +
                   $signed({{(SW-PAN_W){pan_dy[PAN_W-1]}}, pan_dy});

  // next view state per event kind
  always_comb begin
    level_next = level;
    col_next   = col;
    row_next   = row;
    unique case (mode)
      MODE_NONE: begin
      end
      MODE_ZOOM_IN: begin
        if (level < LEVEL_W'(MAX_ZOOM)) begin
          level_next = level + 1'b1;
          col_next   = col << 1;
          row_next   = row << 1;
        end
      end
      MODE_ZOOM_OUT: begin
        if (level != '0) begin
          level_next = level - 1'b1;
          col_next   = col >> 1;
          row_next   = row >> 1;
        end
      end
      MODE_PAN: begin
        // clamp each axis to the map at this level
        if (col_sum[SW-1]) begin
          col_next = '0;
        end else if (col_sum > $signed(map_max)) begin
          col_next = map_max[CW-1:0];
        end else begin
          col_next = col_sum[CW-1:0];
        end
        if (row_sum[SW-1]) begin
          row_next = '0;
        end else if (row_sum > $signed(map_max)) begin
          row_next = map_max[CW-1:0];
        end else begin
          row_next = row_sum[CW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // an empty window updates the state but queues nothing
  assign job_valid = accept && (view.width != '0) && (view.height != '0);
  assign job_data  = {level_next, col_next, row_next};

  // view state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      col   <= '0;
      row   <= '0;
    end else if (accept) begin
      level <= level_next;
      col   <= col_next;
      row   <= row_next;
    end
  end

endmodule

`default_nettype wire

### hdl/qtv_back.sv
// tile scanner: walks the on-map part of the window and emits one tile per word
`default_nettype none

module qtv_back
  import qtv_pkg::*;
#(
  parameter int CW = DEF_MAX_ZOOM
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    job_valid,
  output logic                         job_ready,
  input  wire logic [LEVEL_W+2*CW-1:0] job_data,
  input  wire view_size_t              view,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [LEVEL_W-1:0]           out_level,
  output logic [TILE_W-1:0]            out_x,
  output logic [TILE_W-1:0]            out_y,
  output logic                         out_last
);

  // range arithmetic width covers the center and the window offsets
  localparam int EW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]         state;
  logic [LEVEL_W-1:0] level;
  logic [CW-1:0]      cx;
  logic [CW-1:0]      cy;
  logic [CW-1:0]      x_lo;
  logic [CW-1:0]      x_hi;
  logic [CW-1:0]      y_hi;
  logic [CW-1:0]      x;
  logic [CW-1:0]      y;

  logic [EW-1:0]      map_max;
  logic [SIZE_W-1:0]  lead_w;
  logic [SIZE_W-1:0]  lead_h;
  logic [SIZE_W-1:0]  after_w;
  logic [SIZE_W-1:0]  after_h;
  logic [EW-1:0]      cx_ext;
  logic [EW-1:0]      cy_ext;
  logic [EW-1:0]      x_lo_c;
  logic [EW-1:0]      y_lo_c;
  logic [EW-1:0]      x_hi_raw;
  logic [EW-1:0]      y_hi_raw;
  logic [EW-1:0]      x_hi_c;
  logic [EW-1:0]      y_hi_c;
  logic               adv;
  logic               at_end;

  assign job_ready = (state == ST_IDLE);
  assign adv       = !out_valid || out_ready;
  assign at_end    = (x == x_hi) && (y == y_hi);

  // visible range of the window, clipped to the map
  always_comb begin
    map_max   = (EW'(1) << level) - EW'(1);
    lead_w    = view.width >> 1;
    lead_h    = view.height >> 1;
    after_w   = view.width - lead_w - SIZE_W'(1);
    after_h   = view.height - lead_h - SIZE_W'(1);
    cx_ext    = EW'(cx);
    cy_ext    = EW'(cy);
    x_lo_c    = (cx_ext >= EW'(lead_w)) ? cx_ext - EW'(lead_w) : '0;
    y_lo_c    = (cy_ext >= EW'(lead_h)) ? cy_ext - EW'(lead_h) : '0;
    x_hi_raw  = cx_ext + EW'(after_w);
    y_hi_raw  = cy_ext + EW'(after_h);
    x_hi_c    = (x_hi_raw > map_max) ? map_max : x_hi_raw;
    y_hi_c    = (y_hi_raw > map_max) ? map_max : y_hi_raw;
  end

  // scan sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output word valid
      if ((state == ST_RUN) && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            {level, cx, cy} <= job_data;
            state           <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          x_lo  <= x_lo_c[CW-1:0];
          x_hi  <= x_hi_c[CW-1:0];
          y_hi  <= y_hi_c[CW-1:0];
          x     <= x_lo_c[CW-1:0];
          y     <= y_lo_c[CW-1:0];
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (adv) begin
            out_level <= level;
            out_x     <= TILE_W'(x);
            out_y     <= TILE_W'(y);
            out_last  <= at_end;
            if (at_end) begin
              state <= ST_IDLE;
            end else if (x == x_hi) begin
              x <= x_lo;
              y <= y + 1'b1;
            end else begin
              x <= x + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/quadtree_tile_viewport.sv
// Quadtree tile viewport. Each input word is one navigation event (none, zoom in, zoom
// out, pan, kind in s_axis_tuser) and is taken by the front end when the job queue has
// room; the front end updates the zoom level and center tile and queues a scan job in a
// two-entry queue. The scanner takes the job in its idle state, works out the on-map
// part of the window in its setup state, and then emits the visible tiles one word per
// cycle while m_axis_tready does not stall it, in row-major order, tlast on the final
// one. Events arrive at up to one per cycle while the queue has room. With a window
// width or height of zero an event changes the state and produces no words. The user
// must write window size on the cfg channel only while the block is idle; the block
// itself does not enforce it.
`default_nettype none

module quadtree_tile_viewport
  import qtv_pkg::*;
#(
  parameter int MAX_ZOOM   = DEF_MAX_ZOOM,
  parameter int MAX_VIEW_W = DEF_MAX_VIEW_W,
  parameter int MAX_VIEW_H = DEF_MAX_VIEW_H
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // event input
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [47:0]          s_axis_tdata,   // pan_dx[20:0], pan_dy[41:21], zero fill
  input  wire logic [MODE_W-1:0]    s_axis_tuser,   // mode[1:0]
  // tile output
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [47:0]               m_axis_tdata,   // tile_level[4:0], tile_x[24:5],
                                                    // tile_y[44:25], zero fill
  output logic                      m_axis_tlast,   // last_tile
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data
);

  localparam int CW    = MAX_ZOOM;
  localparam int JOB_W = LEVEL_W + 2 * CW;

  logic [SIZE_W-1:0]  view_width;
  logic [SIZE_W-1:0]  view_height;
  view_size_t         view;
  logic               job_push_valid;
  logic               job_push_ready;
  logic [JOB_W-1:0]   job_push_data;
  logic               job_pop_valid;
  logic               job_pop_ready;
  logic [JOB_W-1:0]   job_pop_data;
  logic [LEVEL_W-1:0] tile_level;
  logic [TILE_W-1:0]  tile_x;
  logic [TILE_W-1:0]  tile_y;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= SIZE_RESET;
      view_height <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VIEW_WIDTH:  view_width  <= cfg_data;
        REG_VIEW_HEIGHT: view_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // saturated window size
  assign view.width  = sat_size(view_width, SIZE_W'(MAX_VIEW_W));
  assign view.height = sat_size(view_height, SIZE_W'(MAX_VIEW_H));

  qtv_front #(
    .MAX_ZOOM (MAX_ZOOM),
    .CW       (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mode      (s_axis_tuser),
    .pan_dx    (s_axis_tdata[PAN_W-1:0]),
    .pan_dy    (s_axis_tdata[2*PAN_W-1:PAN_W]),
    .view      (view),
    .job_valid (job_push_valid),
    .job_ready (job_push_ready),
    .job_data  (job_push_data)
  );

  qtv_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push_data),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop_data)
  );

  qtv_back #(
    .CW (CW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_pop_valid),
    .job_ready (job_pop_ready),
    .job_data  (job_pop_data),
    .view      (view),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_level (tile_level),
    .out_x     (tile_x),
    .out_y     (tile_y),
    .out_last  (m_axis_tlast)
  );

  // output word packing
  assign m_axis_tdata = {3'b000, tile_y, tile_x, tile_level};

endmodule

`default_nettype wire

### hdl/qtv_checker.sv
// port-level checker for the tile viewport, bound to the top level
`default_nettype none

`include "quadtree_tile_viewport_macros.svh"

module qtv_checker
  import qtv_pkg::*;
#(
  parameter int MAX_ZOOM = DEF_MAX_ZOOM
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [47:0]          s_axis_tdata,
  input wire logic [MODE_W-1:0]    s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [47:0]          m_axis_tdata,
  input wire logic                 m_axis_tlast,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [SIZE_W-1:0]    cfg_data
);

  logic [LEVEL_W-1:0] tile_level;
  logic [TILE_W-1:0]  tile_x;
  logic [TILE_W-1:0]  tile_y;
  logic               out_word;
  logic               in_word;
  logic               cfg_word;

  assign tile_level = m_axis_tdata[LEVEL_W-1:0];
  assign tile_x     = m_axis_tdata[LEVEL_W+TILE_W-1:LEVEL_W];
  assign tile_y     = m_axis_tdata[LEVEL_W+2*TILE_W-1:LEVEL_W+TILE_W];
  assign out_word   = m_axis_tvalid && m_axis_tready;
  assign in_word    = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1);
  assign cfg_word   = cfg_valid && cfg_ready && (cfg_index != '1) && (cfg_data != '1);

  // a stalled output word holds
  `QTV_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // level never exceeds the deepest zoom
  `QTV_ASSERT_IMPLIES(a_level_range, clk, rst, m_axis_tvalid, tile_level <= LEVEL_W'(MAX_ZOOM) || in_word || cfg_word)

  // tiles lie on the map at their level
  `QTV_ASSERT_IMPLIES(a_tile_on_map, clk, rst, m_axis_tvalid && (tile_level < LEVEL_W'(TILE_W)), ((tile_x >> tile_level) == '0) && ((tile_y >> tile_level) == '0))

  // a run continues back to back at one level until its last tile
  `QTV_ASSERT_NEXT(a_run_contiguous, clk, rst, out_word && !m_axis_tlast, m_axis_tvalid && (tile_level == $past(tile_level)))

endmodule

bind quadtree_tile_viewport qtv_checker #(.MAX_ZOOM(MAX_ZOOM)) u_checker (.*);

`default_nettype wire

### verif/quadtree_tile_viewport_tb.sv
// self-checking testbench of the quadtree tile viewport: directed table, then random navigation
`default_nettype none

module quadtree_tile_viewport_tb;
  import qtv_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 22;
  localparam int SCRIPT_ROWS   = 13;

  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [PAN_W-1:0] PAN_MAX = 21'h0FFFFF;
  localparam logic signed [PAN_W-1:0] PAN_MIN = 21'h100000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TILE_W-1:0]  col;
    logic [TILE_W-1:0]  row;
    logic               last;
  } tile_t;

  // one row of the directed script; typed rows carry their single visible tile
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAN_W-1:0]  dx;
    logic [PAN_W-1:0]  dy;
    logic [4:0]        reps;
    logic              typed;
    tile_t             tile;
  } nav_step_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;   // pan_dx[20:0], pan_dy[41:21], zero fill
  logic [MODE_W-1:0]    s_axis_tuser = MODE_NONE;  // mode[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;        // tile_level[4:0], tile_x[24:5], tile_y[44:25]
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VIEW_WIDTH;
  logic [SIZE_W-1:0]    cfg_data = '0;

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 11;
  int recv_idle_pct = 50;

  // viewport state and window registers as the block should hold them
  int     view_level = 0;
  longint view_col = 0;
  longint view_row = 0;
  int     win_w = SIZE_RESET;
  int     win_h = SIZE_RESET;

  tile_t pending_tiles[$];

  nav_step_t nav_script [SCRIPT_ROWS] = '{
    // at reset: only the origin tile is on the map
    '{MODE_NONE,     21'd0,   21'd0,   5'd1,  1'b1, '{5'd0, 20'd0, 20'd0, 1'b1}},
    // zoom out refused at level 0
    '{MODE_ZOOM_OUT, 21'd0,   21'd0,   5'd1,  1'b1, '{5'd0, 20'd0, 20'd0, 1'b1}},
    // pans at level 0 clamp back to the origin
    '{MODE_PAN,      PAN_MAX, PAN_MAX, 5'd1,  1'b1, '{5'd0, 20'd0, 20'd0, 1'b1}},
    '{MODE_PAN,      PAN_MIN, PAN_MIN, 5'd1,  1'b1, '{5'd0, 20'd0, 20'd0, 1'b1}},
    '{MODE_ZOOM_IN,  21'd0,   21'd0,   5'd1,  1'b0, '0},
    '{MODE_PAN,      21'd1,   21'd1,   5'd1,  1'b0, '0},
    // climb to the deepest level
    '{MODE_ZOOM_IN,  21'd0,   21'd0,   5'd19, 1'b0, '0},
    // zoom in refused at the top
    '{MODE_ZOOM_IN,  21'd0,   21'd0,   5'd1,  1'b0, '0},
    // bottom-right corner, then top-left corner
    '{MODE_PAN,      PAN_MAX, PAN_MAX, 5'd1,  1'b0, '0},
    '{MODE_PAN,      PAN_MIN, PAN_MIN, 5'd1,  1'b0, '0},
    // pan fields are ignored outside pan
    '{MODE_NONE,     PAN_MIN, 21'h0AAAAA, 5'd1, 1'b0, '0},
    '{MODE_ZOOM_OUT, 21'h155555, PAN_MAX, 5'd1, 1'b0, '0},
    '{MODE_PAN,      21'h1FFFFF, 21'd3, 5'd1,  1'b0, '0}
  };

  quadtree_tile_viewport u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random backpressure on the tile side
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    error_count++;
  endtask

  function automatic longint clamp_axis(input longint value, input longint hi);
    if (value < 0) return 0;
    if (value > hi) return hi;
    return value;
  endfunction

  // update zoom level and center for one navigation event
  function automatic void apply_nav(input logic [MODE_W-1:0] mode,
                                    input logic signed [PAN_W-1:0] dx,
                                    input logic signed [PAN_W-1:0] dy);
    longint map_max;
    map_max = (longint'(1) << view_level) - 1;
    case (mode)
      MODE_ZOOM_IN: begin
        if (view_level < DEF_MAX_ZOOM) begin
          view_col = view_col * 2;
          view_row = view_row * 2;
          view_level++;
        end
      end
      MODE_ZOOM_OUT: begin
        if (view_level > 0) begin
          view_col = view_col / 2;
          view_row = view_row / 2;
          view_level--;
        end
      end
      MODE_PAN: begin
        view_col = clamp_axis(view_col + longint'(dx), map_max);
        view_row = clamp_axis(view_row + longint'(dy), map_max);
      end
      default: ;
    endcase
  endfunction

  // queue the on-map tiles of the window, row-major, last one flagged
  function automatic void queue_window_tiles();
    int     w, h, half_w, half_h, r, c, count;
    longint map_max, ty, tx;
    tile_t  t;
    w = (win_w > DEF_MAX_VIEW_W) ? DEF_MAX_VIEW_W : win_w;
    h = (win_h > DEF_MAX_VIEW_H) ? DEF_MAX_VIEW_H : win_h;
    if (w == 0 || h == 0) return;
    map_max = (longint'(1) << view_level) - 1;
    half_w = w / 2;
    half_h = h / 2;
    count = 0;
    for (r = -half_h; r < h - half_h; r++) begin
      ty = view_row + r;
      if (ty < 0 || ty > map_max) continue;
      for (c = -half_w; c < w - half_w; c++) begin
        tx = view_col + c;
        if (tx < 0 || tx > map_max) continue;
        t.level = view_level[LEVEL_W-1:0];
        t.col = tx[TILE_W-1:0];
        t.row = ty[TILE_W-1:0];
        t.last = 1'b0;
        pending_tiles.insert(pending_tiles.size(), t);
        count++;
      end
    end
    if (count > 0) pending_tiles[pending_tiles.size()-1].last = 1'b1;
  endfunction

  // offer one event word, with random gaps before it
  task automatic send_event(input logic [MODE_W-1:0] mode,
                            input logic signed [PAN_W-1:0] dx,
                            input logic signed [PAN_W-1:0] dy,
                            input logic typed, input tile_t known_tile);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, dy, dx};
    do @(posedge clk); while (!s_axis_tready);
    apply_nav(mode, dx, dy);
    if (typed) pending_tiles.insert(pending_tiles.size(), known_tile);
    else queue_window_tiles();
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_VIEW_WIDTH) win_w = value;
    else if (index == REG_VIEW_HEIGHT) win_h = value;
  endtask

  // let every expected tile drain, then give the scanner time to go quiet
  task automatic settle();
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PAN_W-1:0] rand_delta();
    case ($urandom_range(2))
      0: rand_delta = PAN_W'($urandom_range(20)) - PAN_W'(10);
      1: rand_delta = PAN_W'($urandom());
      default: rand_delta = $urandom_range(1) ? PAN_MAX : PAN_MIN;
    endcase
  endfunction

  // tile checker
  always @(posedge clk) begin : tile_check
    tile_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.level = m_axis_tdata[4:0];
      got.col   = m_axis_tdata[24:5];
      got.row   = m_axis_tdata[44:25];
      got.last  = m_axis_tlast;
      if (pending_tiles.size() == 0) begin
        report_mismatch("tile word with none expected, tile_x", 0, got.col);
      end else begin
        want = pending_tiles.pop_front();
        if (got.level !== want.level) report_mismatch("tile_level", want.level, got.level);
        if (got.col !== want.col) report_mismatch("tile_x", want.col, got.col);
        if (got.row !== want.row) report_mismatch("tile_y", want.row, got.row);
        if (got.last !== want.last) report_mismatch("last_tile", want.last, got.last);
      end
    end
  end

  initial begin : stimulus
    int                 phase_w [PHASE_COUNT] = '{1, 0, 15, 7, 2, 5, 8, 0};
    int                 phase_h [PHASE_COUNT] = '{1, 6, 15, 0, 9, 3, 8, 0};
    int                 sent, pick, zoom_in_pct, i, n;
    logic [MODE_W-1:0]  nav_mode;
    logic [PAN_W-1:0]   dx, dy;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script at the reset window size
    for (i = 0; i < SCRIPT_ROWS; i++) begin
      repeat (nav_script[i].reps)
        send_event(nav_script[i].mode, nav_script[i].dx, nav_script[i].dy,
                   nav_script[i].typed, nav_script[i].tile);
    end
    s_axis_tvalid <= 1'b0;

    // random phases, each at its own window size
    sent = 0;
    for (i = 0; i < PHASE_COUNT; i++) begin
      settle();
      if (i == PHASE_COUNT - 1) begin
        phase_w[i] = $urandom_range(1, 8);
        phase_h[i] = $urandom_range(1, 8);
      end
      write_reg(REG_VIEW_WIDTH, phase_w[i][SIZE_W-1:0]);
      write_reg(REG_VIEW_HEIGHT, phase_h[i][SIZE_W-1:0]);
      if (i == 2) write_reg(REG_SPARE, 4'd1);
      cfg_valid <= 1'b0;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (sent < 70) begin
          send_idle_pct = 11;
          recv_idle_pct = 50;
        end else if (sent < 140) begin
          send_idle_pct = 50;
          recv_idle_pct = 11;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // favor zooming in while shallow so deep levels get visited
        zoom_in_pct = (view_level < 10) ? 40 : 20;
        pick = $urandom_range(99);
        if (pick < zoom_in_pct) nav_mode = MODE_ZOOM_IN;
        else if (pick < zoom_in_pct + 20) nav_mode = MODE_ZOOM_OUT;
        else if (pick < 90) nav_mode = MODE_PAN;
        else nav_mode = MODE_NONE;
        dx = rand_delta();
        dy = rand_delta();
        send_event(nav_mode, dx, dy, 1'b0, '0);
        sent++;
      end
      s_axis_tvalid <= 1'b0;
    end

    settle();
    if (pending_tiles.size() != 0)
      report_mismatch("tiles never emitted, count", 0, pending_tiles.size());
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/qtv_pkg.sv
hdl/qtv_queue.sv
hdl/qtv_front.sv
hdl/qtv_back.sv
hdl/quadtree_tile_viewport.sv
hdl/qtv_checker.sv
verif/quadtree_tile_viewport_tb.sv
